// File: rtl/core/hsae_pkg.sv
// Shared types and constants for the Hall speed and angle estimator.
`default_nettype none

package hsae_pkg;

    localparam int ANGLE_W    = 14;
    localparam int SPEED_W    = 10;
    localparam int CODE_W     = 3;
    localparam int ELAPSED_W  = 16;
    localparam int NUM_CODES  = 8;
    localparam int CFG_IDX_W  = 4;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    localparam int DIV_NUM_W  = 22;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CNT_W  = 5;

    localparam int STEP_W     = 18;
    localparam int MOD_W      = 19;

    localparam int AVG_DEPTH_DEF = 12;

    localparam logic [DIV_NUM_W-1:0] SPEED_NUM   = DIV_NUM_W'(1000000 * 10 / 4);
    localparam logic [STEP_W-1:0]    STEP_NUM    = STEP_W'(1666 * 125);
    localparam logic [DIV_DEN_W-1:0] ANGLE_MOD   = DIV_DEN_W'(10000);
    localparam logic [DIV_NUM_W-1:0] SPEED_LIMIT = DIV_NUM_W'(1000);

    localparam logic [ANGLE_W-1:0] ANGLE_RESET [NUM_CODES] = '{
        ANGLE_W'(0),    ANGLE_W'(8333), ANGLE_W'(5000), ANGLE_W'(6666),
        ANGLE_W'(1666), ANGLE_W'(0),    ANGLE_W'(3333), ANGLE_W'(0)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED,
        ST_RING,
        ST_MEAN,
        ST_STEP,
        ST_MOD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_DEN_W-1:0] denom;
        logic [DIV_NUM_W-1:0] numer;
    } div_req_t;

endpackage

`default_nettype wire

// File: rtl/core/hsae_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module hsae_div
    import hsae_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire div_req_t             req,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quot,
    output logic [DIV_DEN_W-1:0]      rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quot_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // numerator is left aligned by the caller; steps says how many bits to consume
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
        diff   = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.numer;
            den_reg  <= req.denom;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg  <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quot_reg <= {quot_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/hsae_ring.sv
// Moving-average speed ring: memory, valid bits, pointer and running sum.
`default_nettype none

module hsae_ring
    import hsae_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF,
    parameter int SUM_W     = SPEED_W + $clog2(AVG_DEPTH)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [SPEED_W-1:0] speed,
    output logic                    done,
    output logic [SUM_W-1:0]        sum
);

    localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    logic [SPEED_W-1:0]   ring_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] valid_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 upd_reg;
    logic                 done_reg;
    logic [SPEED_W-1:0]   rd_reg;
    logic                 rdv_reg;
    logic [SPEED_W-1:0]   old_val;

    // entries never written since reset read as zero
    assign old_val = rdv_reg ? rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (push)
            rd_reg <= ring_mem[ptr_reg];
        if (upd_reg)
            ring_mem[ptr_reg] <= speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            upd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            upd_reg  <= push;
            done_reg <= upd_reg;
            if (push)
                rdv_reg <= valid_reg[ptr_reg];
            if (upd_reg)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                sum_reg <= sum_reg - SUM_W'(old_val) + SUM_W'(speed);
                if (ptr_reg == PTR_W'(AVG_DEPTH - 1))
                    ptr_reg <= '0;
                else
                    ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire

// File: rtl/core/hall_speed_angle_estimator.sv
// Top level of the Hall sensor speed and angle estimator.
//
// Usage: one input word per control tick on the s_t* channel carries the three
// Hall levels and the elapsed microsecond count. One result word per tick leaves
// on the m_t* channel: interpolated rotor angle, averaged speed, last speed,
// edge flag and Hall code. The cfg_* channel writes the per-code angle table
// (index 0..7; higher indexes are dropped) and is always ready; write it only
// while the block is idle.
//
// Sequencing: one tick at a time through a shared bit-serial divider. A tick
// without a Hall edge runs the angle step (18 bits) and the modulo (19 bits).
// A tick with an edge first runs the speed quotient (22 bits), the ring update
// and the mean (10 + ceil(log2(AVG_DEPTH)) bits); a zero period skips the quotient.
//
// Reset: angle table returns to its default codes, speeds, sums, pointer and
// angle clear, and the ring valid bits clear so every slot reads zero.
// Stall: the result sits in an output register; a finished tick waits there
// until m_tready, while the next word can already be taken and processed.
`default_nettype none

module hall_speed_angle_estimator
    import hsae_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] hall_a, [1] hall_b, [2] hall_c, [18:3] elapsed_count, [23:19] zero
    input  wire logic [S_DATA_W-1:0]  s_tdata,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [13:0] rotor_angle, [23:14] avg_speed, [33:24] last_speed,
    // [34] edge_seen, [37:35] hall_code, [39:38] zero
    output logic [M_DATA_W-1:0]       m_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ANGLE_W-1:0]   cfg_data
);

    localparam int SUM_W = SPEED_W + $clog2(AVG_DEPTH);

    // control
    state_t               state_reg, state_next;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 out_load;

    // estimator state
    logic [ANGLE_W-1:0]   table_reg [NUM_CODES];
    logic [CODE_W-1:0]    prev_hall_reg, prev_hall_next;
    logic [ELAPSED_W-1:0] period_reg, period_next;
    logic [SPEED_W-1:0]   good_reg, good_next;
    logic [SPEED_W-1:0]   speed_now_reg, speed_now_next;
    logic [SPEED_W-1:0]   mean_reg, mean_next;
    logic [ANGLE_W-1:0]   acc_reg, acc_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 edge_reg, edge_next;

    // input word unpacked
    logic [CODE_W-1:0]    in_code;
    logic [ELAPSED_W-1:0] in_elapsed;
    logic                 in_edge;

    // divider and ring
    div_req_t             div_req;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_DEN_W-1:0] div_rem;
    logic                 ring_push;
    logic                 ring_done;
    logic [SUM_W-1:0]     ring_sum;
    logic [MOD_W-1:0]     mod_sum;

    assign in_code    = s_tdata[2:0];
    assign in_elapsed = s_tdata[18:3];
    assign in_edge    = (in_code != prev_hall_reg);

    // acc may hold an unreduced table value; reduced together with this step
    assign mod_sum = MOD_W'(acc_reg) + MOD_W'(div_quot[STEP_W-1:0]);

    hsae_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    hsae_ring #(
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ring_push),
        .speed (speed_now_reg),
        .done  (ring_done),
        .sum   (ring_sum)
    );

    // sequencer: speed (skipped for a zero period) -> ring -> mean on an edge, then angle step -> modulo
    always_comb
    begin
        state_next     = state_reg;
        prev_hall_next = prev_hall_reg;
        period_next    = period_reg;
        good_next      = good_reg;
        speed_now_next = speed_now_reg;
        mean_next      = mean_reg;
        acc_next       = acc_reg;
        code_next      = code_reg;
        edge_next      = edge_reg;
        div_req        = '0;
        ring_push      = 1'b0;
        s_tready       = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    code_next = in_code;
                    edge_next = in_edge;
                    if (in_edge)
                    begin
                        prev_hall_next = in_code;
                        acc_next       = table_reg[in_code];
                        period_next    = (in_elapsed == '0) ? ELAPSED_W'(1) : in_elapsed;
                        if (in_elapsed != '0)
                        begin
                            div_req.start = 1'b1;
                            div_req.numer = SPEED_NUM;
                            div_req.denom = in_elapsed;
                            div_req.steps = DIV_CNT_W'(DIV_NUM_W);
                            state_next    = ST_SPEED;
                        end
                        else
                        begin
                            // zero period: speed 0, which is a good speed
                            good_next      = '0;
                            speed_now_next = '0;
                            ring_push      = 1'b1;
                            state_next     = ST_RING;
                        end
                    end
                    else
                    begin
                        period_next   = (period_reg == '0) ? ELAPSED_W'(1) : period_reg;
                        div_req.start = 1'b1;
                        div_req.numer = DIV_NUM_W'(STEP_NUM) << (DIV_NUM_W - STEP_W);
                        div_req.denom = period_next;
                        div_req.steps = DIV_CNT_W'(STEP_W);
                        state_next    = ST_STEP;
                    end
                end
            end

            ST_SPEED:
            begin
                if (div_done)
                begin
                    // full-width compare; over the limit keeps the last good speed
                    if (div_quot > SPEED_LIMIT)
                        speed_now_next = good_reg;
                    else
                    begin
                        speed_now_next = div_quot[SPEED_W-1:0];
                        good_next      = div_quot[SPEED_W-1:0];
                    end
                    ring_push  = 1'b1;
                    state_next = ST_RING;
                end
            end

            ST_RING:
            begin
                if (ring_done)
                begin
                    div_req.start = 1'b1;
                    div_req.numer = DIV_NUM_W'(ring_sum) << (DIV_NUM_W - SUM_W);
                    div_req.denom = DIV_DEN_W'(AVG_DEPTH);
                    div_req.steps = DIV_CNT_W'(SUM_W);
                    state_next    = ST_MEAN;
                end
            end

            ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_next     = div_quot[SPEED_W-1:0];
                    div_req.start = 1'b1;
                    div_req.numer = DIV_NUM_W'(STEP_NUM) << (DIV_NUM_W - STEP_W);
                    div_req.denom = period_reg;
                    div_req.steps = DIV_CNT_W'(STEP_W);
                    state_next    = ST_STEP;
                end
            end

            ST_STEP:
            begin
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.numer = DIV_NUM_W'(mod_sum) << (DIV_NUM_W - MOD_W);
                    div_req.denom = ANGLE_MOD;
                    div_req.steps = DIV_CNT_W'(MOD_W);
                    state_next    = ST_MOD;
                end
            end

            ST_MOD:
            begin
                if (div_done)
                begin
                    acc_next   = div_rem[ANGLE_W-1:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            prev_hall_reg <= '0;
            period_reg    <= '0;
            good_reg      <= '0;
            speed_now_reg <= '0;
            mean_reg      <= '0;
            acc_reg       <= '0;
            code_reg      <= '0;
            edge_reg      <= 1'b0;
            for (int i = 0; i < NUM_CODES; i++)
                table_reg[i] <= ANGLE_RESET[i];
        end
        else
        begin
            state_reg     <= state_next;
            prev_hall_reg <= prev_hall_next;
            period_reg    <= period_next;
            good_reg      <= good_next;
            speed_now_reg <= speed_now_next;
            mean_reg      <= mean_next;
            acc_reg       <= acc_next;
            code_reg      <= code_next;
            edge_reg      <= edge_next;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            // indexes past the table are dropped
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CODES)))
                table_reg[cfg_index[CODE_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {2'b00, code_reg, edge_reg, speed_now_reg, mean_reg, acc_reg};
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: tb/sv/tb_hall_speed_angle_estimator.sv
// Self-checking testbench for the Hall speed and angle estimator.
module tb_hall_speed_angle_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    import hsae_pkg::*;

    // Scaling of the estimator, kept here on its own so the package is not trusted blindly.
    localparam int unsigned SPEED_SCALE      = 2500000;  // speed = SPEED_SCALE / period
    localparam int unsigned ANGLE_STEP_SCALE = 208250;   // advance = ANGLE_STEP_SCALE / period
    localparam int unsigned ANGLE_TURN       = 10000;    // angle counts per electrical turn
    localparam int unsigned SPEED_CAP        = 1000;     // speeds above this are rejected
    localparam int          RING_DEPTH       = 12;       // moving-average length

    localparam logic [ANGLE_W-1:0] ANGLE_REG_MAX   = '1;
    localparam logic [ANGLE_W-1:0] ANGLE_LEGAL_MAX = ANGLE_W'(ANGLE_TURN - 1);
    localparam logic [ANGLE_W-1:0] DEFAULT_ANGLE [NUM_CODES] = '{
        ANGLE_W'(0),    ANGLE_W'(8333), ANGLE_W'(5000), ANGLE_W'(6666),
        ANGLE_W'(1666), ANGLE_W'(0),    ANGLE_W'(3333), ANGLE_W'(0)
    };

    // Six-step commutation order of a healthy motor, forward direction.
    localparam int HALL_STEPS = 6;
    localparam logic [CODE_W-1:0] HALL_SEQ [HALL_STEPS] = '{
        CODE_W'(1), CODE_W'(3), CODE_W'(2), CODE_W'(6), CODE_W'(4), CODE_W'(5)
    };

    localparam int PHASE_TICKS    = 315;    // random ticks per angle-table setting
    localparam int NUM_PHASES     = 6;
    localparam int PAUSE_PHASE    = 3;      // sender rests mid-phase until all results are back
    localparam int HOLD_AT_RESULT = 520;    // result count that triggers the long m_tready hold
    localparam int HOLD_CYCLES    = 2000;
    localparam int TAIL_CYCLES    = 200;    // wait after the drain for stray result words
    localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles; well above the long hold

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_CODE0 = 0,
        REG_ANGLE_CODE1 = 1,
        REG_ANGLE_CODE2 = 2,
        REG_ANGLE_CODE3 = 3,
        REG_ANGLE_CODE4 = 4,
        REG_ANGLE_CODE5 = 5,
        REG_ANGLE_CODE6 = 6,
        REG_ANGLE_CODE7 = 7,
        REG_UNMAPPED_LO = 8,
        REG_UNMAPPED_HI = 15
    } cfg_reg_t;

    typedef enum int {
        SET_RANDOM_LEGAL,
        SET_ALL_ZERO,
        SET_ALL_MAX,
        SET_ALL_LEGAL_MAX,
        SET_RANDOM_RAW,
        SET_DEFAULTS
    } angle_set_t;

    localparam angle_set_t PHASE_SET [NUM_PHASES] = '{
        SET_RANDOM_LEGAL, SET_ALL_ZERO, SET_ALL_MAX,
        SET_ALL_LEGAL_MAX, SET_RANDOM_RAW, SET_DEFAULTS
    };

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    // Result word as laid out on m_tdata, lowest field last.
    typedef struct packed {
        logic [CODE_W-1:0]  hall_code;
        logic               edge_seen;
        logic [SPEED_W-1:0] last_speed;
        logic [SPEED_W-1:0] avg_speed;
        logic [ANGLE_W-1:0] rotor_angle;
    } tick_result_t;

    typedef struct {
        row_kind_t            kind;
        logic [CODE_W-1:0]    code;
        logic [ELAPSED_W-1:0] elapsed;
        logic [CFG_IDX_W-1:0] index;
        logic [ANGLE_W-1:0]   value;
        bit                   typed;     // result written out by hand
        tick_result_t         result;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_data  = '0;

    always #2 clk = ~clk;

    hall_speed_angle_estimator #(
        .AVG_DEPTH (RING_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Estimator state as the testbench tracks it
    // ---------------------------------------------------------------------
    logic [ANGLE_W-1:0]   angle_by_code [NUM_CODES];
    logic [CODE_W-1:0]    last_code;
    logic [ELAPSED_W-1:0] period_cnt;
    logic [SPEED_W-1:0]   held_speed;     // last speed that passed the cap
    logic [SPEED_W-1:0]   shown_speed;
    logic [SPEED_W-1:0]   mean_speed;
    logic [SPEED_W-1:0]   speed_hist [RING_DEPTH];
    int unsigned          hist_sum;
    int                   hist_ptr;
    logic [ANGLE_W-1:0]   angle_pos;

    tick_result_t pending_results [$];   // results owed by the block, oldest first
    int           fail_count   = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    int           tx_calm      = 0;      // words left in a no-gap run, sender side
    int           rx_calm      = 0;      // same for the receiver
    bit           hold_request = 1'b0;

    function automatic void estimator_reset();
        for (int c = 0; c < NUM_CODES; c++)
            angle_by_code[c] = DEFAULT_ANGLE[c];
        for (int i = 0; i < RING_DEPTH; i++)
            speed_hist[i] = '0;
        last_code   = '0;
        period_cnt  = '0;
        held_speed  = '0;
        shown_speed = '0;
        mean_speed  = '0;
        hist_sum    = 0;
        hist_ptr    = 0;
        angle_pos   = '0;
    endfunction

    // One control tick: Hall edge handling, speed cap, averaging, angle advance.
    function automatic tick_result_t estimate_tick(logic [CODE_W-1:0] code,
                                                   logic [ELAPSED_W-1:0] elapsed);
        tick_result_t r;
        int unsigned  spd;
        int unsigned  acc;
        bit           moved;
        moved = (code != last_code);
        if (moved) begin
            last_code  = code;
            angle_pos  = angle_by_code[code];
            period_cnt = elapsed;
            spd = (elapsed == 0) ? 0 : SPEED_SCALE / elapsed;
            // a zero period gives speed 0, which is a legal speed
            if (spd > SPEED_CAP)
                spd = held_speed;
            else
                held_speed = SPEED_W'(spd);
            shown_speed = SPEED_W'(spd);
            hist_sum = hist_sum - speed_hist[hist_ptr] + spd;
            speed_hist[hist_ptr] = SPEED_W'(spd);
            hist_ptr = (hist_ptr + 1) % RING_DEPTH;
            mean_speed = SPEED_W'(hist_sum / RING_DEPTH);
        end
        // zero period is pinned to 1 and stays there until the next edge
        if (period_cnt == 0)
            period_cnt = 1;
        // table entries above the modulus fold in together with the advance
        acc = angle_pos + ANGLE_STEP_SCALE / period_cnt;
        angle_pos = ANGLE_W'(acc % ANGLE_TURN);
        r.rotor_angle = angle_pos;
        r.avg_speed   = mean_speed;
        r.last_speed  = shown_speed;
        r.edge_seen   = moved;
        r.hall_code   = code;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(tick_result_t got);
        tick_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("rotor_angle", want.rotor_angle, got.rotor_angle);
        compare_field("avg_speed",   want.avg_speed,   got.avg_speed);
        compare_field("last_speed",  want.last_speed,  got.last_speed);
        compare_field("edge_seen",   want.edge_seen,   got.edge_seen);
        compare_field("hall_code",   want.hall_code,   got.hall_code);
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long gap.
    // Every so often a run of words with no gap at all.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            calm = $urandom_range(80, 20);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Periods clustered around the speed cap, plus tiny, long and fully random ones.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return ELAPSED_W'($urandom_range(3));
        if (roll < 30)
            return ELAPSED_W'($urandom_range(2600, 2400));
        if (roll < 40)
            return ELAPSED_W'($urandom_range(2399, 1));
        if (roll < 85)
            return ELAPSED_W'($urandom_range(65535, 2601));
        return ELAPSED_W'($urandom());
    endfunction

    function automatic stim_row_t tick_row(logic [CODE_W-1:0] code,
                                           logic [ELAPSED_W-1:0] elapsed);
        stim_row_t r;
        r = '{kind: ROW_TICK, code: code, elapsed: elapsed, index: '0, value: '0,
              typed: 1'b0, result: '0};
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [CODE_W-1:0] code,
                                            logic [ELAPSED_W-1:0] elapsed,
                                            logic [ANGLE_W-1:0] angle,
                                            logic [SPEED_W-1:0] avg,
                                            logic [SPEED_W-1:0] last,
                                            logic edge_bit);
        stim_row_t r;
        r = tick_row(code, elapsed);
        r.typed  = 1'b1;
        r.result = '{hall_code: code, edge_seen: edge_bit, last_speed: last,
                     avg_speed: avg, rotor_angle: angle};
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] index,
                                            logic [ANGLE_W-1:0] value);
        stim_row_t r;
        r = '{kind: ROW_WRITE, code: '0, elapsed: '0, index: index, value: value,
              typed: 1'b0, result: '0};
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side. Tasks start and return at a falling edge.
    // ---------------------------------------------------------------------
    task automatic send_tick(logic [CODE_W-1:0] code, logic [ELAPSED_W-1:0] elapsed,
                             bit typed = 1'b0, tick_result_t typed_result = '0);
        int           gap;
        tick_result_t guess;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - ELAPSED_W - CODE_W){1'b0}}, elapsed, code};
        do @(posedge clk); while (!s_tready);
        // predictor runs even for hand-written rows so its state keeps up
        guess = estimate_tick(code, elapsed);
        pending_results.push_back(typed ? typed_result : guess);
        @(negedge clk);
    endtask

    // Stop offering words and wait until every owed result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Caller drains first and drops cfg_valid after the last write of a batch.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [ANGLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (index < NUM_CODES)
            angle_by_code[index] = value;   // unmapped indexes are dropped
        @(negedge clk);
    endtask

    task automatic load_angles(angle_set_t setting);
        logic [ANGLE_W-1:0] value;
        drain();
        for (int c = 0; c < NUM_CODES; c++) begin
            case (setting)
                SET_ALL_ZERO:      value = '0;
                SET_ALL_MAX:       value = ANGLE_REG_MAX;
                SET_ALL_LEGAL_MAX: value = ANGLE_LEGAL_MAX;
                SET_RANDOM_RAW:    value = ANGLE_W'($urandom());
                SET_DEFAULTS:      value = DEFAULT_ANGLE[c];
                default:           value = ANGLE_W'($urandom_range(ANGLE_TURN - 1));
            endcase
            write_reg(CFG_IDX_W'(REG_ANGLE_CODE0 + c), value);
        end
        // one write to an unmapped index per batch; it must change nothing
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                  ANGLE_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    // Mostly a spinning rotor: the six-step sequence in either direction, with
    // several ticks between edges. The rest is random codes (0 and 7 too).
    task automatic random_tick(inout int pos, inout int dir);
        logic [CODE_W-1:0] code;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            code = CODE_W'($urandom_range(NUM_CODES - 1));
        end else begin
            if (roll < 15)
                dir = -dir;
            if ($urandom_range(99) < 35)
                pos = (pos + dir + HALL_STEPS) % HALL_STEPS;
            code = HALL_SEQ[pos];
        end
        send_tick(code, pick_elapsed());
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: random m_tready gaps, one long hold while words keep coming.
    // ---------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = pick_gap(rx_calm);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;   // block fills up and backs up its input
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_seen++;
            if (results_seen == HOLD_AT_RESULT)
                hold_request = 1'b1;
            check_result(tick_result_t'(m_tdata[$bits(tick_result_t)-1:0]));
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                   || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("hall_speed_angle_estimator regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        stim_row_t rows [$];
        bit        writing;
        int        pos;
        int        dir;

        estimator_reset();

        // Directed part. Hand-written results hold right after reset with the
        // default table; the rest go through the predictor.
        // no edge from reset code 0, period pinned to 1: 208250 % 10000
        rows.push_back(typed_row(CODE_W'(0), ELAPSED_W'(123), ANGLE_W'(8250),
                                 '0, '0, 1'b0));
        // edge with zero period: speed 0, angle 8333 plus full step
        rows.push_back(typed_row(CODE_W'(1), ELAPSED_W'(0), ANGLE_W'(6583),
                                 '0, '0, 1'b1));
        // period 1: speed far over the cap, last good speed (0) is reused
        rows.push_back(typed_row(CODE_W'(3), ELAPSED_W'(1), ANGLE_W'(4916),
                                 '0, '0, 1'b1));
        rows.push_back(tick_row(CODE_W'(3), ELAPSED_W'(65535)));   // no edge, period stays 1
        rows.push_back(tick_row(CODE_W'(2), ELAPSED_W'(2500)));    // speed exactly at cap
        rows.push_back(tick_row(CODE_W'(6), ELAPSED_W'(2497)));    // just over the cap
        rows.push_back(tick_row(CODE_W'(4), ELAPSED_W'(2501)));    // just under the cap
        rows.push_back(tick_row(CODE_W'(5), ELAPSED_W'(65535)));   // slowest period
        rows.push_back(tick_row(CODE_W'(5), ELAPSED_W'(0)));       // no edge, tiny step
        rows.push_back(tick_row(CODE_W'(7), ELAPSED_W'(40000)));   // illegal code, still an edge
        rows.push_back(tick_row(CODE_W'(0), ELAPSED_W'(0)));       // zero period on edge
        rows.push_back(tick_row(CODE_W'(0), ELAPSED_W'(0)));       // period held at 1
        // table extremes, including entries past the modulus and unmapped indexes
        rows.push_back(write_row(REG_ANGLE_CODE0, ANGLE_REG_MAX));
        rows.push_back(write_row(REG_ANGLE_CODE1, '0));
        rows.push_back(write_row(REG_ANGLE_CODE2, ANGLE_LEGAL_MAX));
        rows.push_back(write_row(REG_ANGLE_CODE3, ANGLE_W'(ANGLE_TURN)));
        rows.push_back(write_row(REG_ANGLE_CODE4, ANGLE_W'(1)));
        rows.push_back(write_row(REG_ANGLE_CODE5, ANGLE_W'(12345)));
        rows.push_back(write_row(REG_ANGLE_CODE6, ANGLE_W'(8192)));
        rows.push_back(write_row(REG_ANGLE_CODE7, ANGLE_REG_MAX));
        rows.push_back(write_row(REG_UNMAPPED_LO, '0));
        rows.push_back(write_row(REG_UNMAPPED_HI, ANGLE_REG_MAX));
        rows.push_back(tick_row(CODE_W'(7), ELAPSED_W'(3000)));    // loads 16383, folds
        rows.push_back(tick_row(CODE_W'(0), ELAPSED_W'(0)));       // loads 16383, full step
        rows.push_back(tick_row(CODE_W'(3), ELAPSED_W'(20000)));   // loads exactly the modulus
        rows.push_back(tick_row(CODE_W'(2), ELAPSED_W'(7)));       // over cap after good speeds

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        writing = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                if (!writing)
                    drain();
                writing = 1'b1;
                write_reg(rows[i].index, rows[i].value);
            end else begin
                if (writing)
                    cfg_valid <= 1'b0;
                writing = 1'b0;
                send_tick(rows[i].code, rows[i].elapsed, rows[i].typed, rows[i].result);
            end
        end

        // Random part: one table setting per phase, block idle at each change.
        pos = 0;
        dir = 1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_angles(PHASE_SET[ph]);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == PAUSE_PHASE && n == PHASE_TICKS / 2)
                    drain();   // sender rests until the block has emptied
                random_tick(pos, dir);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);   // catch any stray result word
        if (fail_count == 0)
            $display("hall_speed_angle_estimator regression: pass");
        else
            $display("hall_speed_angle_estimator regression: fail");
        $finish;
    end

endmodule
